// File: src/battery_charge_controller_core_macros.svh
// Assertion macros shared by the battery charge controller RTL.
// Needs no other file; the asserting files include it by name.
`ifndef BATTERY_CHARGE_CONTROLLER_CORE_MACROS_SVH
`define BATTERY_CHARGE_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define BCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bcc assertion failed");
// Check that cond never holds outside reset.
`define BCC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bcc forbidden condition seen");
`else
`define BCC_ASSERT(label, clk, rst_n, prop)
`define BCC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: src/bcc_pkg.sv
// Types, register indexes and reset values of the battery charge controller.
// Depends on nothing; the RTL modules all import it.
package bcc_pkg;

    localparam int VoltW   = 19;
    localparam int TicksW  = 20;
    localparam int BounceW = 8;
    localparam int OffW    = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 20;

    // Charger phases
    localparam logic [1:0] PH_OFF      = 2'd0;
    localparam logic [1:0] PH_CHARGING = 2'd1;
    localparam logic [1:0] PH_CHARGED  = 2'd2;
    localparam logic [1:0] PH_OOS      = 2'd3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DETECT_THR   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HOLD_THR     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_CONTACT  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MIN_CHARGE   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MAX_CHARGE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_RECHARGE     = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_MAX_BOUNCES  = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_LOCK_RELEASE = 3'd7;

    // Reset values: 4.40 V and 4.00 V in 3.16, 30 minutes and 8x that in 20 ms ticks
    localparam logic [VoltW-1:0]   RST_DETECT_THR   = 19'd288358;
    localparam logic [VoltW-1:0]   RST_HOLD_THR     = 19'd262144;
    localparam logic [TicksW-1:0]  RST_MIN_CONTACT  = 20'd25;
    localparam logic [TicksW-1:0]  RST_MIN_CHARGE   = 20'd250;
    localparam logic [TicksW-1:0]  RST_MAX_CHARGE   = 20'd90000;
    localparam logic [TicksW-1:0]  RST_RECHARGE     = 20'd720000;
    localparam logic [BounceW-1:0] RST_MAX_BOUNCES  = 8'd5;
    localparam logic [OffW-1:0]    RST_LOCK_RELEASE = 16'd250;

    localparam logic [TicksW-1:0]  CONTACT_MAX = {TicksW{1'b1}};
    localparam logic [BounceW-1:0] BOUNCE_MAX  = {BounceW{1'b1}};
    localparam logic [OffW-1:0]    OFF_MAX     = {OffW{1'b1}};

    typedef struct packed {
        logic [VoltW-1:0] vext_voltage;
        logic             charger_done;
        logic             charge_disabled;
    } t_in;

    typedef struct packed {
        logic [1:0] phase;
        logic       charge_enable;
        logic       on_contacts;
        logic       on_charger;
        logic       wake_request;
    } t_out;

    typedef struct packed {
        logic [VoltW-1:0]   detect_threshold;
        logic [VoltW-1:0]   hold_threshold;
        logic [TicksW-1:0]  min_contact_ticks;
        logic [TicksW-1:0]  min_charge_ticks;
        logic [TicksW-1:0]  max_charge_ticks;
        logic [TicksW-1:0]  recharge_ticks;
        logic [BounceW-1:0] max_bounces;
        logic [OffW-1:0]    lockout_release_ticks;
    } t_cfg;

endpackage

// File: src/bcc_cfg_regs.sv
// Configuration register file of the battery charge controller.
// Depends on bcc_pkg.
module bcc_cfg_regs import bcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_threshold      <= RST_DETECT_THR;
            r_cfg.hold_threshold        <= RST_HOLD_THR;
            r_cfg.min_contact_ticks     <= RST_MIN_CONTACT;
            r_cfg.min_charge_ticks      <= RST_MIN_CHARGE;
            r_cfg.max_charge_ticks      <= RST_MAX_CHARGE;
            r_cfg.recharge_ticks        <= RST_RECHARGE;
            r_cfg.max_bounces           <= RST_MAX_BOUNCES;
            r_cfg.lockout_release_ticks <= RST_LOCK_RELEASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DETECT_THR:   r_cfg.detect_threshold      <= i_cfg_data[VoltW-1:0];
                CFG_HOLD_THR:     r_cfg.hold_threshold        <= i_cfg_data[VoltW-1:0];
                CFG_MIN_CONTACT:  r_cfg.min_contact_ticks     <= i_cfg_data[TicksW-1:0];
                CFG_MIN_CHARGE:   r_cfg.min_charge_ticks      <= i_cfg_data[TicksW-1:0];
                CFG_MAX_CHARGE:   r_cfg.max_charge_ticks      <= i_cfg_data[TicksW-1:0];
                CFG_RECHARGE:     r_cfg.recharge_ticks        <= i_cfg_data[TicksW-1:0];
                CFG_MAX_BOUNCES:  r_cfg.max_bounces           <= i_cfg_data[BounceW-1:0];
                CFG_LOCK_RELEASE: r_cfg.lockout_release_ticks <= i_cfg_data[OffW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/bcc_engine.sv
// Per-tick state update of the battery charge controller: contact detect,
// saturating counters and the phase machine. Depends on bcc_pkg.
module bcc_engine import bcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_result
);

    logic [1:0]         r_phase,   n_phase;
    logic [TicksW-1:0]  r_contact, n_contact;
    logic [BounceW-1:0] r_bounce,  n_bounce;
    logic [OffW-1:0]    r_off,     n_off;

    logic               on;
    logic               wake;
    logic [TicksW-1:0]  contact_a;
    logic [BounceW-1:0] bounce_inc;
    logic [OffW-1:0]    off_inc;

    always_comb begin
        on = (i_item.vext_voltage > i_cfg.detect_threshold) ||
             ((r_phase == PH_CHARGING) && (i_item.vext_voltage > i_cfg.hold_threshold));

        // Contact counter: clear off contacts, saturate on contacts
        wake = 1'b0;
        if (!on) begin
            contact_a = '0;
        end else if (r_contact != CONTACT_MAX) begin
            contact_a = r_contact + 1'b1;
            wake      = (contact_a == i_cfg.min_contact_ticks);
        end else begin
            contact_a = r_contact;
        end

        bounce_inc = (r_bounce != BOUNCE_MAX) ? r_bounce + 1'b1 : r_bounce;
        off_inc    = (r_off != OFF_MAX) ? r_off + 1'b1 : r_off;

        n_phase   = r_phase;
        n_contact = contact_a;
        n_bounce  = r_bounce;
        n_off     = r_off;

        case (r_phase)
            PH_OFF: begin
                if (!i_item.charge_disabled && contact_a >= i_cfg.min_contact_ticks)
                    n_phase = PH_CHARGING;
            end
            PH_CHARGING: begin
                if (i_item.charge_disabled) begin
                    n_phase = PH_OFF;
                end else if ((i_item.charger_done && contact_a >= i_cfg.min_charge_ticks) ||
                             contact_a >= i_cfg.max_charge_ticks) begin
                    n_phase = PH_CHARGED;
                end else if (!on) begin
                    n_bounce = bounce_inc;
                    n_phase  = (bounce_inc > i_cfg.max_bounces) ? PH_OOS : PH_OFF;
                end else if (contact_a > i_cfg.min_charge_ticks) begin
                    n_bounce = '0;
                end
            end
            PH_CHARGED: begin
                // Off contacts forces the counter to zero, so the two cases never overlap
                if (!on) begin
                    n_phase = PH_OFF;
                end else if (contact_a > i_cfg.recharge_ticks) begin
                    n_contact = i_cfg.min_contact_ticks;
                    n_phase   = PH_CHARGING;
                end
            end
            default: begin
                if (!on) begin
                    n_off = off_inc;
                    if (off_inc > i_cfg.lockout_release_ticks) begin
                        n_phase  = PH_OFF;
                        n_bounce = '0;
                    end
                end else begin
                    n_off = '0;
                end
            end
        endcase

        o_result.phase         = n_phase;
        o_result.charge_enable = (n_phase == PH_CHARGING);
        o_result.on_contacts   = on;
        o_result.on_charger    = (n_contact > i_cfg.min_contact_ticks);
        o_result.wake_request  = wake;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OFF;
            r_contact <= '0;
            r_bounce  <= '0;
            r_off     <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_contact <= n_contact;
            r_bounce  <= n_bounce;
            r_off     <= n_off;
        end
    end

endmodule

// File: src/battery_charge_controller_core.sv
// Battery charge controller: one measurement tick in, one status result out.
// A tick is taken every clock cycle as long as the result side keeps up; each
// tick is held in the input register until the result register can take it;
// its result is then registered there and raises o_valid. A stalled result
// holds the tick in the input register and raises o_stall. The rate
// of one tick per cycle is set by the single update of the phase and counter
// registers, which runs once per tick. Configuration writes land in a register
// file and take effect on the next tick; write only while no tick is in
// flight. Depends on bcc_pkg, bcc_cfg_regs, bcc_engine and the assertion macro
// header.
`include "battery_charge_controller_core_macros.svh"
module battery_charge_controller_core import bcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Measurement ticks
    input  logic               i_valid,
    input  t_in                i_data,
    output logic               o_stall,
    // Status results
    output logic               o_valid,
    output t_out               o_data,
    input  logic               i_stall,
    // Configuration writes
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data
);

    t_cfg cfg;
    t_out result;

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;

    logic advance;
    logic fire;

    bcc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The result register moves when empty or when its transfer completes
    assign advance = !r_out_valid || !i_stall;
    // Process the held tick whenever the result register can take it
    assign fire    = r_in_valid && advance;
    // Hold off new ticks only while the input register is full and blocked
    assign o_stall = r_in_valid && !advance;

    bcc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register: load on every transfer, drain when processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
    end

    // Result register: hold while stalled, else take the new result or empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // A processed tick always shows up as a result on the next edge
    `BCC_ASSERT(a_fire_to_result, i_clk, i_rst_n, fire |=> r_out_valid)
    // Charger enable follows the charging phase in every result
    `BCC_ASSERT(a_enable_phase, i_clk, i_rst_n,
        r_out_valid |-> (r_out.charge_enable == (r_out.phase == PH_CHARGING)))
    // A wake pulse only comes on a tick with contacts
    `BCC_ASSERT_NEVER(a_wake_off_contacts, i_clk, i_rst_n,
        r_out_valid && r_out.wake_request && !r_out.on_contacts)
    // A blocked input register keeps its tick
    `BCC_ASSERT(a_hold_input, i_clk, i_rst_n, o_stall |=> r_in_valid)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for battery_charge_controller_core: drives measurement ticks,
// predicts each status result in SystemVerilog and compares every field.
// Depends on bcc_pkg and the controller RTL only.
module tb;
    import bcc_pkg::*;

    localparam int               DRAIN_CYCLES = 4;   // pipeline depth plus margin
    localparam int               RESET_ROWS   = 4;   // rows run with the reset configuration
    localparam int               DIR_ROWS     = 25;
    localparam logic [VoltW-1:0] VOLT_MAX     = {VoltW{1'b1}};
    localparam logic [VoltW-1:0] DIR_HI       = 19'd200000;  // above the directed detect level
    localparam logic [VoltW-1:0] DIR_MID      = 19'd70000;   // between hold and detect
    localparam logic [VoltW-1:0] DIR_LO       = 19'd1000;    // below both levels
    localparam t_out             NO_CHECK     = '0;

    typedef enum { V_ABOVE, V_BETWEEN, V_BELOW, V_ANY } t_volt_kind;

    // One directed row: the tick, whether a hand-written status follows, and that status.
    typedef struct packed {
        t_in  tick;
        logic typed;
        t_out want;
    } t_dir_row;

    // Columns: voltage, charger_done, charge_disabled | typed | phase, enable, contacts,
    // on_charger, wake.
    t_dir_row dir_rows [DIR_ROWS] = '{
        // reset configuration: floor, ceiling and the exact detect boundary
        {19'd0,                 1'b0, 1'b0, 1'b1, PH_OFF,      1'b0, 1'b0, 1'b0, 1'b0},
        {VOLT_MAX,              1'b1, 1'b1, 1'b1, PH_OFF,      1'b0, 1'b1, 1'b0, 1'b0},
        {RST_DETECT_THR,        1'b0, 1'b0, 1'b1, PH_OFF,      1'b0, 1'b0, 1'b0, 1'b0},
        {RST_DETECT_THR + 19'd1, 1'b0, 1'b0, 1'b1, PH_OFF,     1'b0, 1'b1, 1'b0, 1'b0},
        // directed configuration: reach charging, then hold on the lower level
        {DIR_LO,                1'b0, 1'b0, 1'b1, PH_OFF,      1'b0, 1'b0, 1'b0, 1'b0},
        {DIR_HI,                1'b0, 1'b0, 1'b1, PH_OFF,      1'b0, 1'b1, 1'b0, 1'b0},
        {DIR_HI,                1'b0, 1'b0, 1'b1, PH_CHARGING, 1'b1, 1'b1, 1'b0, 1'b1},
        {DIR_MID,               1'b0, 1'b0, 1'b0, NO_CHECK},
        // first contact loss is tolerated, the mid level no longer holds off charger
        {DIR_LO,                1'b0, 1'b0, 1'b1, PH_OFF,      1'b0, 1'b0, 1'b0, 1'b0},
        {DIR_MID,               1'b0, 1'b0, 1'b0, NO_CHECK},
        // second loss exceeds the bounce budget: lockout
        {DIR_HI,                1'b0, 1'b0, 1'b0, NO_CHECK},
        {DIR_HI,                1'b0, 1'b0, 1'b0, NO_CHECK},
        {DIR_LO,                1'b0, 1'b0, 1'b1, PH_OOS,      1'b0, 1'b0, 1'b0, 1'b0},
        // contact during lockout restarts the off count, then release
        {DIR_LO,                1'b0, 1'b0, 1'b0, NO_CHECK},
        {VOLT_MAX,              1'b1, 1'b1, 1'b0, NO_CHECK},
        {DIR_LO,                1'b0, 1'b0, 1'b0, NO_CHECK},
        {DIR_LO,                1'b0, 1'b0, 1'b0, NO_CHECK},
        {DIR_LO,                1'b0, 1'b0, 1'b0, NO_CHECK},
        // charge, charger done after the minimum time, then the recharge restart
        {DIR_HI,                1'b0, 1'b0, 1'b0, NO_CHECK},
        {DIR_HI,                1'b0, 1'b0, 1'b0, NO_CHECK},
        {DIR_HI,                1'b1, 1'b0, 1'b1, PH_CHARGED,  1'b0, 1'b1, 1'b1, 1'b0},
        {DIR_HI,                1'b0, 1'b0, 1'b0, NO_CHECK},
        {DIR_HI,                1'b0, 1'b0, 1'b0, NO_CHECK},
        // disabled while charging drops to the off phase without a bounce
        {DIR_HI,                1'b0, 1'b1, 1'b0, NO_CHECK},
        {DIR_HI,                1'b0, 1'b0, 1'b0, NO_CHECK}
    };

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               tick_valid   = 1'b0;
    t_in                tick_data    = '0;
    logic               tick_typed   = 1'b0;
    t_out               tick_want    = '0;
    logic               tick_stall;
    logic               status_valid;
    t_out               status_data;
    logic               status_stall = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx      = '0;
    logic [CfgW-1:0]    cfg_data     = '0;

    // Predictor state and its copy of the register file
    t_cfg               active_cfg;
    logic [1:0]         ph_now;
    logic [TicksW-1:0]  contact_run;
    logic [BounceW-1:0] bounce_tally;
    logic [OffW-1:0]    off_run;

    t_out status_pending [$];   // predicted status, oldest first
    int   fail_count = 0;
    int   idle_pct   = 0;       // chance per cycle that a gap or stall burst starts
    int   stall_left = 0;

    battery_charge_controller_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (tick_valid),
        .i_data     (tick_data),
        .o_stall    (tick_stall),
        .o_valid    (status_valid),
        .o_data     (status_data),
        .i_stall    (status_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: one measurement tick in, the status after its update out.
    // ------------------------------------------------------------------
    function automatic t_out advance_charger(t_in tick);
        t_out r;
        logic in_contact;
        logic wake;
        in_contact = tick.vext_voltage > active_cfg.detect_threshold ||
                     (ph_now == PH_CHARGING && tick.vext_voltage > active_cfg.hold_threshold);
        wake = 1'b0;
        // Count ticks on contacts, saturating; wake only on a real increment
        if (!in_contact) begin
            contact_run = '0;
        end else if (contact_run != CONTACT_MAX) begin
            contact_run = contact_run + 1'b1;
            wake = contact_run == active_cfg.min_contact_ticks;
        end
        case (ph_now)
            PH_OFF: begin
                if (!tick.charge_disabled && contact_run >= active_cfg.min_contact_ticks)
                    ph_now = PH_CHARGING;
            end
            PH_CHARGING: begin
                if (tick.charge_disabled) begin
                    ph_now = PH_OFF;
                end else if ((tick.charger_done &&
                              contact_run >= active_cfg.min_charge_ticks) ||
                             contact_run >= active_cfg.max_charge_ticks) begin
                    ph_now = PH_CHARGED;
                end else if (!in_contact) begin
                    if (bounce_tally != BOUNCE_MAX)
                        bounce_tally = bounce_tally + 1'b1;
                    ph_now = (bounce_tally > active_cfg.max_bounces) ? PH_OOS : PH_OFF;
                end else if (contact_run > active_cfg.min_charge_ticks) begin
                    bounce_tally = '0;
                end
            end
            PH_CHARGED: begin
                if (contact_run > active_cfg.recharge_ticks) begin
                    contact_run = active_cfg.min_contact_ticks;
                    ph_now = PH_CHARGING;
                end
                if (!in_contact)
                    ph_now = PH_OFF;
            end
            default: begin
                // Lockout: the off count survives leaving this phase
                if (!in_contact) begin
                    if (off_run != OFF_MAX)
                        off_run = off_run + 1'b1;
                    if (off_run > active_cfg.lockout_release_ticks) begin
                        ph_now = PH_OFF;
                        bounce_tally = '0;
                    end
                end else begin
                    off_run = '0;
                end
            end
        endcase
        r.phase         = ph_now;
        r.charge_enable = ph_now == PH_CHARGING;
        r.on_contacts   = in_contact;
        r.on_charger    = contact_run > active_cfg.min_contact_ticks;
        r.wake_request  = wake;
        return r;
    endfunction

    function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Predict on every tick transfer; a directed row may carry its own status.
    always @(posedge clk) begin : take_tick
        t_out predicted;
        if (rst_n && tick_valid && !tick_stall) begin
            predicted = advance_charger(tick_data);
            status_pending.push_back(tick_typed ? tick_want : predicted);
        end
    end

    // Compare every status transfer with the oldest prediction.
    always @(posedge clk) begin : check_status
        t_out want;
        if (rst_n && status_valid && !status_stall) begin
            if (status_pending.size() == 0) begin
                $error("status transfer with no tick waiting for it");
                fail_count++;
            end else begin
                want = status_pending.pop_front();
                check_field("phase", want.phase, status_data.phase);
                check_field("charge_enable", 2'(want.charge_enable),
                            2'(status_data.charge_enable));
                check_field("on_contacts", 2'(want.on_contacts),
                            2'(status_data.on_contacts));
                check_field("on_charger", 2'(want.on_charger),
                            2'(status_data.on_charger));
                check_field("wake_request", 2'(want.wake_request),
                            2'(status_data.wake_request));
            end
        end
    end

    // Result side: stall in bursts that start at random, none while idle_pct is zero.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            status_stall <= 1'b1;
            stall_left   <= $urandom_range(7, 0);
        end else begin
            status_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one tick, maybe after a gap, and hold it until the transfer.
    task automatic send_tick(t_in t, logic typed = 1'b0, t_out want = '0);
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_data  <= t;
        tick_typed <= typed;
        tick_want  <= want;
        @(posedge clk);
        while (tick_stall) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted status has come back.
    task automatic drain_status();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (status_pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; fill the bits above its width with junk to prove masking.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
        logic [CfgW-1:0] word;
        word = CfgW'($urandom);
        case (idx)
            CFG_DETECT_THR: begin
                word[VoltW-1:0] = value[VoltW-1:0];
                active_cfg.detect_threshold = value[VoltW-1:0];
            end
            CFG_HOLD_THR: begin
                word[VoltW-1:0] = value[VoltW-1:0];
                active_cfg.hold_threshold = value[VoltW-1:0];
            end
            CFG_MIN_CONTACT: begin
                word = value;
                active_cfg.min_contact_ticks = value;
            end
            CFG_MIN_CHARGE: begin
                word = value;
                active_cfg.min_charge_ticks = value;
            end
            CFG_MAX_CHARGE: begin
                word = value;
                active_cfg.max_charge_ticks = value;
            end
            CFG_RECHARGE: begin
                word = value;
                active_cfg.recharge_ticks = value;
            end
            CFG_MAX_BOUNCES: begin
                word[BounceW-1:0] = value[BounceW-1:0];
                active_cfg.max_bounces = value[BounceW-1:0];
            end
            CFG_LOCK_RELEASE: begin
                word[OffW-1:0] = value[OffW-1:0];
                active_cfg.lockout_release_ticks = value[OffW-1:0];
            end
            default: ;
        endcase
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= word;
        @(posedge clk);
    endtask

    // Write the whole register file back to back, then release the write enable.
    task automatic load_config(t_cfg c);
        write_reg(CFG_DETECT_THR, CfgW'(c.detect_threshold));
        write_reg(CFG_HOLD_THR, CfgW'(c.hold_threshold));
        write_reg(CFG_MIN_CONTACT, CfgW'(c.min_contact_ticks));
        write_reg(CFG_MIN_CHARGE, CfgW'(c.min_charge_ticks));
        write_reg(CFG_MAX_CHARGE, CfgW'(c.max_charge_ticks));
        write_reg(CFG_RECHARGE, CfgW'(c.recharge_ticks));
        write_reg(CFG_MAX_BOUNCES, CfgW'(c.max_bounces));
        write_reg(CFG_LOCK_RELEASE, CfgW'(c.lockout_release_ticks));
        cfg_we <= 1'b0;
    endtask

    // Short counts so every phase is reached within a few dozen ticks.
    function automatic t_cfg small_cfg(bit inverted_hyst);
        t_cfg c;
        c.detect_threshold = VoltW'($urandom_range(500000, 20000));
        if (inverted_hyst)
            c.hold_threshold = VoltW'($urandom_range(VOLT_MAX, c.detect_threshold));
        else
            c.hold_threshold = VoltW'($urandom_range(c.detect_threshold, 0));
        c.min_contact_ticks     = TicksW'($urandom_range(6, 0));
        c.min_charge_ticks      = TicksW'($urandom_range(12, 0));
        c.max_charge_ticks      = TicksW'($urandom_range(40, 0));
        c.recharge_ticks        = TicksW'($urandom_range(30, 0));
        c.max_bounces           = BounceW'($urandom_range(6, 0));
        c.lockout_release_ticks = OffW'($urandom_range(20, 0));
        return c;
    endfunction

    // Pick a voltage relative to the current thresholds, hitting the boundaries now and then.
    function automatic logic [VoltW-1:0] pick_voltage(t_volt_kind kind);
        logic [VoltW-1:0] low_thr;
        low_thr = (active_cfg.hold_threshold < active_cfg.detect_threshold) ?
                  active_cfg.hold_threshold : active_cfg.detect_threshold;
        case (kind)
            V_ABOVE: begin
                if (active_cfg.detect_threshold == VOLT_MAX)
                    return VOLT_MAX;
                if ($urandom_range(7, 0) == 0)
                    return active_cfg.detect_threshold + 1'b1;
                return VoltW'($urandom_range(VOLT_MAX, active_cfg.detect_threshold + 1));
            end
            V_BETWEEN: begin
                if (active_cfg.hold_threshold >= active_cfg.detect_threshold)
                    return active_cfg.detect_threshold;
                return VoltW'($urandom_range(active_cfg.detect_threshold,
                                             active_cfg.hold_threshold + 1));
            end
            V_BELOW: begin
                if ($urandom_range(7, 0) == 0)
                    return low_thr;
                return VoltW'($urandom_range(low_thr, 0));
            end
            default: return VoltW'($urandom);
        endcase
    endfunction

    function automatic t_in make_tick(t_volt_kind kind);
        t_in t;
        t.vext_voltage = pick_voltage(kind);
        if (kind == V_ANY) begin
            t.charger_done    = 1'($urandom_range(1, 0));
            t.charge_disabled = 1'($urandom_range(1, 0));
        end else begin
            t.charger_done    = $urandom_range(7, 0) == 0;
            t.charge_disabled = $urandom_range(19, 0) == 0;
        end
        return t;
    endfunction

    // A tick with charger done and disable both low.
    task automatic send_plain(t_volt_kind kind);
        t_in t;
        t = make_tick(kind);
        t.charger_done    = 1'b0;
        t.charge_disabled = 1'b0;
        send_tick(t);
    endtask

    // Mostly contact episodes followed by time off contacts; the rest is raw noise.
    task automatic run_episodes(int n_ticks);
        int         sent;
        int         len;
        int         j;
        int         roll;
        t_volt_kind kind;
        sent = 0;
        while (sent < n_ticks) begin
            if ($urandom_range(99, 0) < 15) begin
                len = $urandom_range(8, 1);
                for (j = 0; j < len; j++) begin
                    send_tick(make_tick(V_ANY));
                    sent++;
                end
            end else begin
                len = $urandom_range(60, 1);
                for (j = 0; j < len; j++) begin
                    roll = $urandom_range(99, 0);
                    if (roll < 80)
                        kind = V_ABOVE;
                    else if (roll < 94)
                        kind = V_BETWEEN;
                    else
                        kind = V_BELOW;
                    send_tick(make_tick(kind));
                    sent++;
                end
                len = $urandom_range(30, 1);
                for (j = 0; j < len; j++) begin
                    send_tick(make_tick(V_BELOW));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_cfg c;
        t_in  t;
        int   k;
        int   p;

        // Mirror the reset state of the block
        active_cfg.detect_threshold      = RST_DETECT_THR;
        active_cfg.hold_threshold        = RST_HOLD_THR;
        active_cfg.min_contact_ticks     = RST_MIN_CONTACT;
        active_cfg.min_charge_ticks      = RST_MIN_CHARGE;
        active_cfg.max_charge_ticks      = RST_MAX_CHARGE;
        active_cfg.recharge_ticks        = RST_RECHARGE;
        active_cfg.max_bounces           = RST_MAX_BOUNCES;
        active_cfg.lockout_release_ticks = RST_LOCK_RELEASE;
        ph_now       = PH_OFF;
        contact_run  = '0;
        bounce_tally = '0;
        off_run      = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table; switch to the short directed counts after the reset rows
        idle_pct = 20;
        for (k = 0; k < DIR_ROWS; k++) begin
            if (k == RESET_ROWS) begin
                drain_status();
                c.detect_threshold      = 19'd100000;
                c.hold_threshold        = 19'd50000;
                c.min_contact_ticks     = 20'd2;
                c.min_charge_ticks      = 20'd3;
                c.max_charge_ticks      = 20'd8;
                c.recharge_ticks        = 20'd4;
                c.max_bounces           = 8'd1;
                c.lockout_release_ticks = 16'd2;
                load_config(c);
            end
            send_tick(dir_rows[k].tick, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random episodes under several short configurations, one with inverted
        // hysteresis and one without any idling
        for (p = 0; p < 5; p++) begin
            drain_status();
            load_config(small_cfg(p == 3));
            idle_pct = (p == 2) ? 0 : 15;
            run_episodes(210);
        end

        // Every register at its floor
        drain_status();
        load_config('0);
        run_episodes(100);

        // Every register at its ceiling, the bounce budget one below: contacts can never be detected
        drain_status();
        c.detect_threshold      = VOLT_MAX;
        c.hold_threshold        = VOLT_MAX;
        c.min_contact_ticks     = CONTACT_MAX;
        c.min_charge_ticks      = CONTACT_MAX;
        c.max_charge_ticks      = CONTACT_MAX;
        c.recharge_ticks        = CONTACT_MAX;
        c.max_bounces           = 8'd254;
        c.lockout_release_ticks = OFF_MAX;
        load_config(c);
        run_episodes(50);

        // Bounce until the count tops out at the largest budget, then release
        drain_status();
        c.detect_threshold      = 19'd100000;
        c.hold_threshold        = 19'd50000;
        c.min_contact_ticks     = '0;
        c.lockout_release_ticks = 16'd3;
        load_config(c);
        idle_pct = 10;
        for (k = 0; k < 256; k++) begin
            send_plain(V_ABOVE);
            send_plain(V_BELOW);
        end
        for (k = 0; k < 5; k++)
            send_plain(V_BELOW);

        // From here on no idling. Lock out and stay off contacts well past
        // the release time.
        idle_pct = 0;
        drain_status();
        c.max_bounces = '0;
        c.lockout_release_ticks = 16'd30;
        load_config(c);
        send_plain(V_ABOVE);
        send_plain(V_BELOW);
        for (k = 0; k < 40; k++)
            send_plain(V_BELOW);

        // The off count kept from the last lockout is above the new release
        // time, so the next lockout releases on its first tick off contacts
        drain_status();
        c.lockout_release_ticks = 16'd10;
        load_config(c);
        send_plain(V_BELOW);
        send_plain(V_ABOVE);
        send_plain(V_BELOW);
        send_plain(V_BELOW);

        // Hold contacts with charging disabled; the wake pulse comes once when
        // the count reaches the minimum and never again
        drain_status();
        c.detect_threshold  = '0;
        c.hold_threshold    = '0;
        c.min_contact_ticks = 20'd20;
        load_config(c);
        for (k = 0; k < 30; k++) begin
            t.vext_voltage    = VoltW'($urandom_range(VOLT_MAX, 1));
            t.charger_done    = 1'($urandom_range(1, 0));
            t.charge_disabled = 1'b1;
            send_tick(t);
        end
        send_tick('0);

        drain_status();
        if (fail_count == 0 && status_pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: several times the longest correct run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
